/* rtl/cdad_pkg.sv */
// Package for the calendar date adder: shared types, calendar constants
// and month-length helpers. No dependencies; used by every module of the block.
package cdad_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFFSET_W = 17;

    // Working year carries a bias of one 400-year cycle so it never goes negative.
    localparam int YB_W   = 15;
    localparam int MOD_W  = 9;
    localparam int DACC_W = 18;

    localparam logic [YB_W-1:0]    YEAR_BIAS   = 15'd400;
    localparam logic [YB_W-1:0]    YB_LOW_MIN  = 15'd401;
    localparam logic [YB_W-1:0]    YB_HIGH_MAX = 15'd10399;
    localparam logic [MOD_W-1:0]   CYCLE_LAST  = 9'd399;
    localparam logic [MOD_W-1:0]   CENTURY_1   = 9'd100;
    localparam logic [MOD_W-1:0]   CENTURY_2   = 9'd200;
    localparam logic [MOD_W-1:0]   CENTURY_3   = 9'd300;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [YEAR_W-1:0]  SAT_YEAR_LOW  = 14'd1;
    localparam logic [YEAR_W-1:0]  SAT_YEAR_HIGH = 14'd9999;
    localparam logic [DAY_W-1:0]   SAT_DAY_LOW   = 5'd1;
    localparam logic [DAY_W-1:0]   SAT_DAY_HIGH  = 5'd31;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } cdad_cmd_t;

    typedef struct packed {
        logic done;
    } cdad_status_t;

    // Year modulo 400 by six restoring compare-and-subtract steps.
    function automatic logic [MOD_W-1:0] year_mod400(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] r;
        r = y;
        if (r >= 14'd12800) r = r - 14'd12800;
        if (r >= 14'd6400)  r = r - 14'd6400;
        if (r >= 14'd3200)  r = r - 14'd3200;
        if (r >= 14'd1600)  r = r - 14'd1600;
        if (r >= 14'd800)   r = r - 14'd800;
        if (r >= 14'd400)   r = r - 14'd400;
        return r[MOD_W-1:0];
    endfunction

    function automatic logic is_leap(input logic [MOD_W-1:0] r);
        return (r[1:0] == 2'b00) && (r != CENTURY_1) && (r != CENTURY_2)
            && (r != CENTURY_3);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* rtl/cdad_ctrl.sv */
// Controller of the calendar date adder: load, step and publish sequencing,
// plus the output valid flag. Depends on cdad_pkg.
module cdad_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cdad_pkg::cdad_cmd_t    cmd,
    input  cdad_pkg::cdad_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_STEP = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.load    = in_valid && (state_reg == ST_IDLE);
        cmd.step    = (state_reg == ST_STEP);
        cmd.publish = (state_reg == ST_STEP) && status.done
                      && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                    state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (cmd.publish)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/cdad_dpath.sv */
// Datapath of the calendar date adder: month-by-month day stepper and the
// saturating result register. Depends on cdad_pkg.
module cdad_dpath
(
    input  logic                                   clk,
    input  cdad_pkg::cdad_cmd_t                     cmd,
    output cdad_pkg::cdad_status_t                  status,
    input  logic [cdad_pkg::YEAR_W-1:0]            start_year,
    input  logic [cdad_pkg::MONTH_W-1:0]           start_month,
    input  logic [cdad_pkg::DAY_W-1:0]             start_day,
    input  logic signed [cdad_pkg::OFFSET_W-1:0]   day_offset,
    output logic [cdad_pkg::YEAR_W-1:0]            result_year,
    output logic [cdad_pkg::MONTH_W-1:0]           result_month,
    output logic [cdad_pkg::DAY_W-1:0]             result_day,
    output logic                                   out_of_range
);

    logic [cdad_pkg::YB_W-1:0]           yb_reg, yb_next;
    logic [cdad_pkg::MOD_W-1:0]          ymod_reg, ymod_next;
    logic [cdad_pkg::MONTH_W-1:0]        mon_reg, mon_next;
    logic signed [cdad_pkg::DACC_W-1:0]  dacc_reg, dacc_next;

    logic [cdad_pkg::YEAR_W-1:0]         ryear_reg, ryear_next;
    logic [cdad_pkg::MONTH_W-1:0]        rmon_reg, rmon_next;
    logic [cdad_pkg::DAY_W-1:0]          rday_reg, rday_next;
    logic                                rflag_reg, rflag_next;

    logic                                leap;
    logic [cdad_pkg::MONTH_W-1:0]        mon_prev, mon_clamp;
    logic [cdad_pkg::DAY_W-1:0]          len_cur, len_prev;
    logic signed [cdad_pkg::DACC_W-1:0]  len_cur_s, len_prev_s;
    logic                                over, under;
    logic [cdad_pkg::YB_W-1:0]           year_unbiased;

    always_comb
    begin
        leap       = cdad_pkg::is_leap(ymod_reg);
        mon_prev   = (mon_reg == cdad_pkg::MON_JAN) ? cdad_pkg::MON_DEC
                                                    : mon_reg - 4'd1;
        len_cur    = cdad_pkg::month_len(mon_reg, leap);
        len_prev   = cdad_pkg::month_len(mon_prev, leap);
        len_cur_s  = $signed({13'd0, len_cur});
        len_prev_s = $signed({13'd0, len_prev});
        over       = dacc_reg > len_cur_s;
        under      = dacc_reg < 18'sd1;
        status.done = !over && !under;

        if (start_month == 4'd0)
            mon_clamp = cdad_pkg::MON_JAN;
        else if (start_month > cdad_pkg::MON_DEC)
            mon_clamp = cdad_pkg::MON_DEC;
        else
            mon_clamp = start_month;
    end

    // Month stepper: one month crossed per cycle, forward or backward.
    always_comb
    begin
        yb_next   = yb_reg;
        ymod_next = ymod_reg;
        mon_next  = mon_reg;
        dacc_next = dacc_reg;
        if (cmd.load)
        begin
            yb_next   = {1'b0, start_year} + cdad_pkg::YEAR_BIAS;
            ymod_next = cdad_pkg::year_mod400(start_year);
            mon_next  = mon_clamp;
            dacc_next = $signed({13'd0, start_day})
                        + {{(cdad_pkg::DACC_W-cdad_pkg::OFFSET_W){day_offset[16]}},
                           day_offset};
        end
        else if (cmd.step && over)
        begin
            dacc_next = dacc_reg - len_cur_s;
            if (mon_reg == cdad_pkg::MON_DEC)
            begin
                mon_next  = cdad_pkg::MON_JAN;
                yb_next   = yb_reg + 15'd1;
                ymod_next = (ymod_reg == cdad_pkg::CYCLE_LAST) ? 9'd0 : ymod_reg + 9'd1;
            end
            else
                mon_next = mon_reg + 4'd1;
        end
        else if (cmd.step && under)
        begin
            dacc_next = dacc_reg + len_prev_s;
            mon_next  = mon_prev;
            if (mon_reg == cdad_pkg::MON_JAN)
            begin
                yb_next   = yb_reg - 15'd1;
                ymod_next = (ymod_reg == 9'd0) ? cdad_pkg::CYCLE_LAST : ymod_reg - 9'd1;
            end
        end
    end

    always_comb
    begin
        year_unbiased = yb_reg - cdad_pkg::YEAR_BIAS;
        ryear_next = ryear_reg;
        rmon_next  = rmon_reg;
        rday_next  = rday_reg;
        rflag_next = rflag_reg;
        if (cmd.publish)
        begin
            if (yb_reg < cdad_pkg::YB_LOW_MIN)
            begin
                ryear_next = cdad_pkg::SAT_YEAR_LOW;
                rmon_next  = cdad_pkg::MON_JAN;
                rday_next  = cdad_pkg::SAT_DAY_LOW;
                rflag_next = 1'b1;
            end
            else if (yb_reg > cdad_pkg::YB_HIGH_MAX)
            begin
                ryear_next = cdad_pkg::SAT_YEAR_HIGH;
                rmon_next  = cdad_pkg::MON_DEC;
                rday_next  = cdad_pkg::SAT_DAY_HIGH;
                rflag_next = 1'b1;
            end
            else
            begin
                ryear_next = year_unbiased[cdad_pkg::YEAR_W-1:0];
                rmon_next  = mon_reg;
                rday_next  = dacc_reg[cdad_pkg::DAY_W-1:0];
                rflag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        yb_reg    <= yb_next;
        ymod_reg  <= ymod_next;
        mon_reg   <= mon_next;
        dacc_reg  <= dacc_next;
        ryear_reg <= ryear_next;
        rmon_reg  <= rmon_next;
        rday_reg  <= rday_next;
        rflag_reg <= rflag_next;
    end

    assign result_year  = ryear_reg;
    assign result_month = rmon_reg;
    assign result_day   = rday_reg;
    assign out_of_range = rflag_reg;

endmodule

/* rtl/calendar_date_add_days.sv */
// Top level of the calendar date adder: stream ports, controller and datapath.
// Depends on cdad_pkg, cdad_ctrl and cdad_dpath.
//
//   Channel  Direction  Payload                                   Handshake
//   s_*      in         tdata: start date and signed day offset   s_tvalid/s_tready
//   m_*      out        tdata: result date; tuser: out_of_range   m_tvalid/m_tready
//
// An item is loaded, then the month stepper in the datapath crosses one month
// per cycle until the day count lies inside the current month, and the result
// is published. Reset clears the controller and the output valid flag; the
// datapath registers need no reset. A stalled result sits in the output
// register, and the next item is accepted meanwhile; only the final publish
// waits for the slot to free.
module calendar_date_add_days
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // start_year[13:0], start_month[17:14],
                                   // start_day[22:18], day_offset[39:23]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // result_year[13:0], result_month[17:14],
                                   // result_day[22:18], zero pad[23]
    output logic        m_tuser    // out_of_range[0]
);

    cdad_pkg::cdad_cmd_t    cmd;
    cdad_pkg::cdad_status_t status;

    logic [cdad_pkg::YEAR_W-1:0]  result_year;
    logic [cdad_pkg::MONTH_W-1:0] result_month;
    logic [cdad_pkg::DAY_W-1:0]   result_day;
    logic                         out_of_range;

    // The controller owns the handshakes and decides when to load, step and
    // move a finished date into the output register.
    cdad_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath keeps a running day count against the current month and
    // moves one month per cycle until the count falls inside that month.
    cdad_dpath u_dpath
    (
        .clk          (clk),
        .cmd          (cmd),
        .status       (status),
        .start_year   (s_tdata[13:0]),
        .start_month  (s_tdata[17:14]),
        .start_day    (s_tdata[22:18]),
        .day_offset   ($signed(s_tdata[39:23])),
        .result_year  (result_year),
        .result_month (result_month),
        .result_day   (result_day),
        .out_of_range (out_of_range)
    );

    assign m_tdata = {1'b0, result_day, result_month, result_year};
    assign m_tuser = out_of_range;

    // Once an item is taken, the block is busy for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while the previous item was still stepping");

    // A presented result always names a real month and a nonzero day.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[17:14] != 4'd0) && (m_tdata[17:14] <= 4'd12)
                     && (m_tdata[22:18] != 5'd0))
        else $error("result month or day out of range");

    // A flagged result is one of the two saturation dates.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            ((m_tdata[13:0] == 14'd1) && (m_tdata[17:14] == 4'd1)
              && (m_tdata[22:18] == 5'd1))
            || ((m_tdata[13:0] == 14'd9999) && (m_tdata[17:14] == 4'd12)
              && (m_tdata[22:18] == 5'd31)))
        else $error("out_of_range set on a date that is not a saturation limit");

    // An unflagged result lies inside the supported years.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |->
            (m_tdata[13:0] != 14'd0) && (m_tdata[13:0] <= 14'd9999))
        else $error("result year outside 1..9999 without out_of_range");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for calendar_date_add_days: directed and random dates with
// signed day offsets, checked against a day-number predictor kept in this file.
// Depends on cdad_pkg and the calendar_date_add_days RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // The date arithmetic counts days from a March 1 far in the past. Every year
    // carries a bias of one full Gregorian cycle so that no divided value goes
    // negative.
    localparam longint YEARS_PER_CYCLE = 400;
    localparam longint DAYS_PER_CYCLE  = 146097;
    localparam longint YEAR_SHIFT      = 400;

    // The slowest item steps about 2150 months, one per cycle, and the receiver
    // stalls only now and then at random, so a limit many times that is ample.
    localparam int STALL_LIMIT  = 40000;
    localparam int TAIL_CYCLES  = 64;
    localparam int RANDOM_ITEMS = 250;

    // Stretch of items (and of results) during which neither side stalls at random.
    localparam int CALM_FIRST = 120;
    localparam int CALM_LAST  = 180;

    // Laid out so that the struct maps straight onto s_tdata, year in the lowest bits.
    typedef struct packed {
        logic signed [cdad_pkg::OFFSET_W-1:0] offset;
        logic [cdad_pkg::DAY_W-1:0]           day;
        logic [cdad_pkg::MONTH_W-1:0]         month;
        logic [cdad_pkg::YEAR_W-1:0]          year;
    } date_item_t;

    typedef struct packed {
        logic [cdad_pkg::YEAR_W-1:0]  year;
        logic [cdad_pkg::MONTH_W-1:0] month;
        logic [cdad_pkg::DAY_W-1:0]   day;
        logic                         saturated;
    } date_result_t;

    // An item waiting to be sent; drain_first holds it back until every result
    // already owed by the block has come out.
    typedef struct packed {
        logic       drain_first;
        date_item_t dt;
    } queued_date_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    queued_date_t dates_to_send[$];
    date_result_t dates_due[$];

    int items_sent      = 0;
    int results_checked = 0;
    int saturated_seen  = 0;
    int mismatches      = 0;
    int idle_cycles     = 0;

    calendar_date_add_days DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Predicts the shifted date. The start date becomes a serial day number, the
    // offset is added, and the sum is turned back into a date. The month is
    // clamped into 1..12 first; a day of zero or past the month's end simply
    // moves the serial number, which is how those inputs roll over.
    function automatic date_result_t shift_date(input date_item_t it);
        longint yr;
        longint mon;
        longint cycles;
        longint yr_in_cycle;
        longint mar_month;
        longint day_in_year;
        longint day_in_cycle;
        longint serial;
        longint res_yr;
        longint res_mon;
        longint res_day;
        date_result_t res;

        yr  = longint'(it.year);
        mon = longint'(it.month);
        if (mon < longint'(cdad_pkg::MON_JAN))
            mon = longint'(cdad_pkg::MON_JAN);
        if (mon > longint'(cdad_pkg::MON_DEC))
            mon = longint'(cdad_pkg::MON_DEC);

        // January and February count as the tail of the previous year.
        if (mon <= 2)
            yr = yr - 1;
        yr          = yr + YEAR_SHIFT;
        cycles      = yr / YEARS_PER_CYCLE;
        yr_in_cycle = yr - cycles * YEARS_PER_CYCLE;
        mar_month   = (mon > 2) ? (mon - 3) : (mon + 9);
        day_in_year = (153 * mar_month + 2) / 5 + longint'(it.day) - 1;
        serial      = cycles * DAYS_PER_CYCLE + yr_in_cycle * 365 + yr_in_cycle / 4
                    - yr_in_cycle / 100 + day_in_year + longint'($signed(it.offset));
        if (serial < 0)
            serial = 0;

        cycles       = serial / DAYS_PER_CYCLE;
        day_in_cycle = serial - cycles * DAYS_PER_CYCLE;
        yr_in_cycle  = (day_in_cycle - day_in_cycle / 1460 + day_in_cycle / 36524
                     - day_in_cycle / 146096) / 365;
        day_in_year  = day_in_cycle - (365 * yr_in_cycle + yr_in_cycle / 4
                     - yr_in_cycle / 100);
        mar_month    = (5 * day_in_year + 2) / 153;
        res_day      = day_in_year - (153 * mar_month + 2) / 5 + 1;
        res_mon      = (mar_month < 10) ? (mar_month + 3) : (mar_month - 9);
        res_yr       = yr_in_cycle + cycles * YEARS_PER_CYCLE - YEAR_SHIFT;
        if (res_mon <= 2)
            res_yr = res_yr + 1;

        // Results outside 1..9999 clamp to the first or last representable day.
        if (res_yr < 1)
        begin
            res.year      = cdad_pkg::SAT_YEAR_LOW;
            res.month     = cdad_pkg::MON_JAN;
            res.day       = cdad_pkg::SAT_DAY_LOW;
            res.saturated = 1'b1;
        end
        else if (res_yr > 9999)
        begin
            res.year      = cdad_pkg::SAT_YEAR_HIGH;
            res.month     = cdad_pkg::MON_DEC;
            res.day       = cdad_pkg::SAT_DAY_HIGH;
            res.saturated = 1'b1;
        end
        else
        begin
            res.year      = res_yr[cdad_pkg::YEAR_W-1:0];
            res.month     = res_mon[cdad_pkg::MONTH_W-1:0];
            res.day       = res_day[cdad_pkg::DAY_W-1:0];
            res.saturated = 1'b0;
        end
        return res;
    endfunction

    // Queues one date; the values are cut to the field widths, so -65536 lands
    // on the most negative 17-bit pattern.
    task automatic add_date(input int yr, input int mon, input int dd, input int off,
                            input logic drain_first);
        queued_date_t q;

        q.drain_first = drain_first;
        q.dt.year     = yr[cdad_pkg::YEAR_W-1:0];
        q.dt.month    = mon[cdad_pkg::MONTH_W-1:0];
        q.dt.day      = dd[cdad_pkg::DAY_W-1:0];
        q.dt.offset   = off[cdad_pkg::OFFSET_W-1:0];
        dates_to_send.push_back(q);
    endtask

    task automatic check_date(input date_result_t got);
        date_result_t want;

        want = dates_due.pop_front();
        if (got.year !== want.year)
        begin
            $error("result_year: expected %0d, got %0d", want.year, got.year);
            mismatches++;
        end
        if (got.month !== want.month)
        begin
            $error("result_month: expected %0d, got %0d", want.month, got.month);
            mismatches++;
        end
        if (got.day !== want.day)
        begin
            $error("result_day: expected %0d, got %0d", want.day, got.day);
            mismatches++;
        end
        if (got.saturated !== want.saturated)
        begin
            $error("out_of_range: expected %0d, got %0d", want.saturated, got.saturated);
            mismatches++;
        end
    endtask

    // Sender. A new item goes onto the bus only when the slot is free, i.e. the
    // bus is empty or the item on it is being taken at this edge. The expected
    // result of an accepted item is recorded here, from the bus itself.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                dates_due.push_back(shift_date(date_item_t'(s_tdata)));
                items_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (dates_to_send.size() == 0)
                    s_tvalid <= 1'b0;
                else if (dates_to_send[0].drain_first && dates_due.size() != 0)
                    s_tvalid <= 1'b0;
                else if (!(items_sent >= CALM_FIRST && items_sent < CALM_LAST)
                         && $urandom_range(99) < 29)
                    s_tvalid <= 1'b0;
                else
                begin
                    s_tdata  <= dates_to_send[0].dt;
                    s_tvalid <= 1'b1;
                    void'(dates_to_send.pop_front());
                end
            end
        end
    end

    // Receiver: checks every accepted result against the oldest expectation and
    // stalls at random outside the calm stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (dates_due.size() == 0)
                begin
                    $error("result %0d/%0d/%0d arrived with no date outstanding",
                           m_tdata[13:0], m_tdata[17:14], m_tdata[22:18]);
                    mismatches++;
                end
                else
                begin
                    check_date({m_tdata[13:0], m_tdata[17:14], m_tdata[22:18], m_tuser});
                end
                if (m_tuser)
                    saturated_seen++;
                results_checked++;
            end
            m_tready <= (results_checked >= CALM_FIRST && results_checked < CALM_LAST)
                     || ($urandom_range(99) >= 29);
        end
    end

    // Counts cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int sel;
        int yr;
        int mon;
        int dd;
        int off;

        // Directed part: leap-year edges, month and year wraps both ways, offset
        // extremes, clamped months, day zero and day overflow, start years
        // outside 1..9999, and saturation at both calendar limits.
        add_date(2024,  2, 28,      1, 1'b0);  // into a leap day
        add_date(2023,  2, 28,      1, 1'b0);  // common year goes to March 1
        add_date(1900,  2, 28,      1, 1'b0);  // century year is not leap
        add_date(2000,  2, 28,      1, 1'b0);  // but every 400th year is
        add_date(2024, 12, 31,      1, 1'b0);  // year rolls forward
        add_date(2024,  1,  1,     -1, 1'b0);  // year rolls back into December
        add_date(2024,  3,  1,     -1, 1'b0);  // borrow lands on the leap day
        add_date(1999,  7, 14,      0, 1'b0);
        add_date(2000,  1,  1,  65535, 1'b0);  // largest forward step
        add_date(2000,  6, 15, -65536, 1'b0);  // most negative offset pattern
        add_date(2000,  6, 15, -65535, 1'b0);
        add_date(2010,  0, 10,     20, 1'b0);  // month zero reads as January
        add_date(2010, 13,  5,      3, 1'b0);  // months 13..15 read as December
        add_date(2010, 15, 31,     -3, 1'b0);
        add_date(2021,  4, 31,      0, 1'b0);  // day past the month's end
        add_date(2021,  2, 31,      5, 1'b0);
        add_date(2021,  3,  0,      0, 1'b0);  // day zero: last day of February
        add_date(   0,  1,  0,    800, 1'b0);  // year zero on the proleptic calendar
        add_date(16383, 15, 31, -65536, 1'b0); // largest field values, still too late
        add_date(10000,  1,  1, -65536, 1'b0); // out-of-range start, valid result
        add_date(   1,  1,  1,     -1, 1'b0);  // falls before year 1
        add_date(   1,  1,  1, -65536, 1'b0);
        add_date(9999, 12, 31,      1, 1'b0);  // runs past year 9999
        add_date(9999, 12, 31,      0, 1'b0);

        // Random part. Offsets are mostly short, since the block crosses one month
        // per cycle; a few span the whole range. Years cluster in 1..9999 with
        // some near the limits and some anywhere in the 14-bit field.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 10)
                yr = $urandom_range(16383, 0);
            else if (sel < 16)
                yr = $urandom_range(1) ? $urandom_range(3, 1) : $urandom_range(9999, 9996);
            else
                yr = $urandom_range(9999, 1);

            mon = ($urandom_range(99) < 10) ? $urandom_range(15, 0) : $urandom_range(12, 1);
            dd  = ($urandom_range(99) < 10) ? $urandom_range(31, 0) : $urandom_range(31, 1);

            sel = $urandom_range(99);
            if (sel < 60)
                off = int'($urandom_range(800)) - 400;
            else if (sel < 85)
                off = int'($urandom_range(10000)) - 5000;
            else if (sel < 97)
                off = int'($urandom_range(131071)) - 65536;
            else
            begin
                case ($urandom_range(2))
                    0:       off = -65536;
                    1:       off = -65535;
                    default: off = 65535;
                endcase
            end

            // The first random item and one in the middle wait for the block to
            // empty out before they go.
            add_date(yr, mon, dd, off, (n == 0) || (n == RANDOM_ITEMS / 2));
        end

        @(posedge rst_n);
        while (dates_to_send.size() != 0 || s_tvalid)
            @(posedge clk);
        while (dates_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d dates through the adder; %0d results checked, %0d saturated.",
                 items_sent, results_checked, saturated_seen);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
